@@ sv/stu_pkg.sv @@
// stu_pkg: shared types, character codes and the digit decoder for the
// string_to_unsigned_parse block. No dependencies.

package stu_pkg;

   // widths fixed by the word format
   localparam int ValueBits      = 64;
   localparam int OffsetOutBits  = 16;
   localparam int BaseBits       = 6;
   localparam int CsrDataBits    = 32;
   localparam int CsrAddrBits    = 3;
   localparam int OFFSET_BITS_DEF = 16;

   // register index of number_base on the config port
   localparam logic REG_NUMBER_BASE = 1'b0;

   // character codes
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_VT    = 8'h0B;
   localparam logic [7:0] CH_FF    = 8'h0C;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_UA    = 8'h41;
   localparam logic [7:0] CH_UX    = 8'h58;
   localparam logic [7:0] CH_UZ    = 8'h5A;
   localparam logic [7:0] CH_LA    = 8'h61;
   localparam logic [7:0] CH_LX    = 8'h78;
   localparam logic [7:0] CH_LZ    = 8'h7A;

   // radix values
   localparam logic [BaseBits-1:0] BASE_AUTO = 6'd0;
   localparam logic [BaseBits-1:0] BASE_MIN  = 6'd2;
   localparam logic [BaseBits-1:0] BASE_OCT  = 6'd8;
   localparam logic [BaseBits-1:0] BASE_DEC  = 6'd10;
   localparam logic [BaseBits-1:0] BASE_HEX  = 6'd16;
   localparam logic [BaseBits-1:0] BASE_MAX  = 6'd36;

   // digit value of a byte that is no digit or letter
   localparam logic [BaseBits-1:0] DIGIT_NONE = 6'd63;

   typedef enum logic [2:0] {
      PH_SPACE,
      PH_SIGNED,
      PH_ZERO,
      PH_XPFX,
      PH_DIGITS,
      PH_DONE
   } parse_phase_type;

   // per-string control state
   typedef struct packed {
      parse_phase_type       phase;
      logic                  minus;
      logic [BaseBits-1:0]   base;
      logic                  seen;
   } stu_ctl_type;

   // result of one step
   typedef struct packed {
      logic                     emit;
      logic [ValueBits-1:0]     value;
      logic [OffsetOutBits-1:0] offset;
      logic                     had;
   } stu_result_type;

   // digit value of a byte, letters of either case count from ten
   function automatic logic [BaseBits-1:0] digit_of(input logic [7:0] c);
      logic [7:0] diff;
      diff = 8'h00;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         diff = c - CH_ZERO;
         return diff[BaseBits-1:0];
      end
      if (c >= CH_LA && c <= CH_LZ) begin
         diff = c - CH_LA + 8'd10;
         return diff[BaseBits-1:0];
      end
      if (c >= CH_UA && c <= CH_UZ) begin
         diff = c - CH_UA + 8'd10;
         return diff[BaseBits-1:0];
      end
      return DIGIT_NONE;
   endfunction

endpackage

@@ sv/stu_step.sv @@
// stu_step: next-state and result logic for one byte of the parser.
// Depends on stu_pkg.

module stu_step import stu_pkg::*; #(
   parameter int POS_BITS = 16
) (
   input  logic [7:0]           char_byte,
   input  logic                 first_byte,
   input  logic [BaseBits-1:0]  number_base,
   input  stu_ctl_type          ctl_cur,
   input  logic [ValueBits-1:0] acc_cur,
   input  logic [POS_BITS-1:0]  pos_cur,
   output stu_ctl_type          next_ctl,
   output logic [ValueBits-1:0] next_acc,
   output logic [POS_BITS-1:0]  next_pos,
   output stu_result_type       result
);

   stu_ctl_type          ctl;
   logic [ValueBits-1:0] acc;
   logic [POS_BITS-1:0]  pos;
   logic [BaseBits-1:0]  dig;
   logic [BaseBits-1:0]  sig_base;
   logic [BaseBits-1:0]  zero_base;
   logic [BaseBits-1:0]  take_base;
   logic                 is_ws;
   logic                 is_sign;
   logic                 is_x;
   logic                 zero_pfx;
   logic                 hex_ok;
   logic                 base_ok;
   parse_phase_type      take_phase;
   parse_phase_type      signif_phase;
   parse_phase_type      phase_in;
   logic [ValueBits+BaseBits-1:0] prod;
   logic [ValueBits-1:0] mac;
   logic [1:0]           pos_step;
   logic [POS_BITS:0]    pos_sum;

   // a first byte restarts the string with the configured base
   always_comb begin
      if (first_byte) begin
         ctl.phase = PH_SPACE;
         ctl.minus = 1'b0;
         ctl.base  = number_base;
         ctl.seen  = 1'b0;
         acc       = '0;
         pos       = '0;
      end else begin
         ctl = ctl_cur;
         acc = acc_cur;
         pos = pos_cur;
      end
   end

   // byte classes
   assign dig      = digit_of(char_byte);
   assign is_ws    = (char_byte == CH_SPACE) || (char_byte == CH_TAB) ||
                     (char_byte == CH_LF) || (char_byte == CH_CR) ||
                     (char_byte == CH_VT) || (char_byte == CH_FF);
   assign is_sign  = (char_byte == CH_PLUS) || (char_byte == CH_MINUS);
   assign is_x     = (char_byte == CH_LX) || (char_byte == CH_UX);
   assign zero_pfx = (char_byte == CH_ZERO) &&
                     ((ctl.base == BASE_AUTO) || (ctl.base == BASE_HEX));
   assign hex_ok   = (dig < BASE_HEX);

   // radix in force for a digit in this phase
   assign sig_base  = (ctl.base == BASE_AUTO) ? BASE_DEC : ctl.base;
   assign zero_base = (ctl.base == BASE_AUTO) ? BASE_OCT : ctl.base;
   always_comb begin
      case (ctl.phase)
         PH_SPACE, PH_SIGNED: take_base = sig_base;
         PH_ZERO:             take_base = zero_base;
         default:             take_base = ctl.base;
      endcase
   end

   assign base_ok = (take_base >= BASE_MIN) && (take_base <= BASE_MAX) &&
                    (dig < take_base);

   // multiply-add of the accumulator
   assign prod = {{BaseBits{1'b0}}, acc} * {{ValueBits{1'b0}}, take_base};
   assign mac  = prod[ValueBits-1:0] + {{(ValueBits-BaseBits){1'b0}}, dig};

   assign take_phase   = base_ok ? PH_DIGITS : PH_DONE;
   assign signif_phase = zero_pfx ? PH_ZERO : take_phase;

   // next phase
   always_comb begin
      case (ctl.phase)
         PH_SPACE: begin
            if (is_ws) begin
               phase_in = PH_SPACE;
            end else if (is_sign) begin
               phase_in = PH_SIGNED;
            end else begin
               phase_in = signif_phase;
            end
         end
         PH_SIGNED: phase_in = signif_phase;
         PH_ZERO:   phase_in = is_x ? PH_XPFX : take_phase;
         PH_XPFX:   phase_in = hex_ok ? PH_DIGITS : PH_DONE;
         PH_DIGITS: phase_in = take_phase;
         default:   phase_in = PH_DONE;
      endcase
   end

   // datapath updates
   always_comb begin
      next_ctl.phase = phase_in;
      next_ctl.minus = ctl.minus;
      next_ctl.base  = ctl.base;
      next_ctl.seen  = ctl.seen;
      next_acc       = acc;
      pos_step       = 2'd0;
      case (ctl.phase)
         PH_SPACE, PH_SIGNED: begin
            if (ctl.phase == PH_SPACE && is_ws) begin
               pos_step = 2'd1;
            end else if (ctl.phase == PH_SPACE && is_sign) begin
               next_ctl.minus = (char_byte == CH_MINUS);
               pos_step       = 2'd1;
            end else if (zero_pfx) begin
               next_acc      = '0;
               next_ctl.seen = 1'b1;
               pos_step      = 2'd1;
            end else begin
               next_ctl.base = sig_base;
               if (base_ok) begin
                  next_acc      = mac;
                  next_ctl.seen = 1'b1;
                  pos_step      = 2'd1;
               end
            end
         end
         PH_ZERO: begin
            if (!is_x) begin
               next_ctl.base = zero_base;
               if (base_ok) begin
                  next_acc      = mac;
                  next_ctl.seen = 1'b1;
                  pos_step      = 2'd1;
               end
            end
         end
         PH_XPFX: begin
            if (hex_ok) begin
               next_ctl.base = BASE_HEX;
               next_acc      = {{(ValueBits-BaseBits){1'b0}}, dig};
               pos_step      = 2'd2;
            end
         end
         PH_DIGITS: begin
            if (base_ok) begin
               next_acc      = mac;
               next_ctl.seen = 1'b1;
               pos_step      = 2'd1;
            end
         end
         default: begin
            pos_step = 2'd0;
         end
      endcase
   end

   // byte index saturates at all ones
   assign pos_sum  = {1'b0, pos} + {{(POS_BITS-1){1'b0}}, pos_step};
   assign next_pos = pos_sum[POS_BITS] ? {POS_BITS{1'b1}} : pos_sum[POS_BITS-1:0];

   // a result leaves on the step that ends the conversion
   assign result.emit   = (phase_in == PH_DONE) && (ctl.phase != PH_DONE);
   assign result.value  = ctl.minus ? (~acc + 64'd1) : acc;
   assign result.offset = ctl.seen ? OffsetOutBits'(pos) : '0;
   assign result.had    = ctl.seen;

endmodule

@@ sv/string_to_unsigned_parse.sv @@
// string_to_unsigned_parse: streaming strtoul-style parser, top level.
// Depends on stu_pkg and stu_step.
//
// Usage:
//   Bytes of a zero-terminated string enter on the req_ channel, one word
//   per byte; req_first_byte marks the first byte of a new string and
//   latches number_base (0 = auto, else radix 2..36). Whitespace and one
//   sign are skipped, then digits are accumulated modulo 2^64. The first
//   byte that is no digit sends one word on the rsp_ channel: the value,
//   the stop offset and had_digits. Later bytes of that string give nothing.
//   Path: a byte is held in the input register, then goes through the
//   step logic (one 64x6 multiply-add) into the state and result registers;
//   a result shows on rsp_ after its byte has passed both registers.
//   Throughput: one byte per cycle while the result register is free or
//   being taken; the accumulator loop through the multiply-add sets this.
//   Stall: while a result waits with rsp_ready low, the byte in the input
//   register waits and req_ready falls once that register is full.
//   Reset: synchronous, clears all parse state to a base-0 string at index
//   zero and sets number_base to 0. The APB port reads back number_base.

module string_to_unsigned_parse import stu_pkg::*; #(
   parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   // byte input
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [7:0]               req_char_byte,
   input  logic                     req_first_byte,
   // result output
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [ValueBits-1:0]     rsp_parsed_value,
   output logic [OffsetOutBits-1:0] rsp_stop_offset,
   output logic                     rsp_had_digits,
   // register port
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CsrAddrBits-1:0]   paddr,
   input  logic [CsrDataBits-1:0]   pwdata,
   output logic [CsrDataBits-1:0]   prdata,
   output logic                     pready
);

   localparam int PosBits = (OFFSET_BITS > OffsetOutBits) ? OffsetOutBits : OFFSET_BITS;

   logic                     in_valid_ff;
   logic [7:0]               in_char_ff;
   logic                     in_first_ff;
   logic                     advance;

   logic [BaseBits-1:0]      number_base_ff;
   stu_ctl_type              ctl_ff;
   stu_ctl_type              ctl_in;
   logic [ValueBits-1:0]     acc_ff;
   logic [ValueBits-1:0]     acc_in;
   logic [PosBits-1:0]       pos_ff;
   logic [PosBits-1:0]       pos_in;
   stu_result_type           step_result;

   logic                     rsp_valid_ff;
   logic [ValueBits-1:0]     rsp_value_ff;
   logic [OffsetOutBits-1:0] rsp_offset_ff;
   logic                     rsp_had_ff;

   logic                     reg_sel;

   // config register
   assign pready  = 1'b1;
   assign reg_sel = (paddr[CsrAddrBits-1] == REG_NUMBER_BASE);
   assign prdata  = reg_sel ? {{(CsrDataBits-BaseBits){1'b0}}, number_base_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         number_base_ff <= BASE_AUTO;
      end else if (psel && penable && pwrite && pready && reg_sel) begin
         number_base_ff <= pwdata[BaseBits-1:0];
      end
   end

   // step advances when the result register can take a new word
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_char_ff  <= req_char_byte;
         in_first_ff <= req_first_byte;
      end
   end

   stu_step #(
      .POS_BITS (PosBits)
   ) u_step (
      .char_byte   (in_char_ff),
      .first_byte  (in_first_ff),
      .number_base (number_base_ff),
      .ctl_cur     (ctl_ff),
      .acc_cur     (acc_ff),
      .pos_cur     (pos_ff),
      .next_ctl    (ctl_in),
      .next_acc    (acc_in),
      .next_pos    (pos_in),
      .result      (step_result)
   );

   // parse state
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.phase <= PH_SPACE;
         ctl_ff.minus <= 1'b0;
         ctl_ff.base  <= BASE_AUTO;
         ctl_ff.seen  <= 1'b0;
         acc_ff       <= '0;
         pos_ff       <= '0;
      end else if (advance) begin
         ctl_ff <= ctl_in;
         acc_ff <= acc_in;
         pos_ff <= pos_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && step_result.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && step_result.emit) begin
         rsp_value_ff  <= step_result.value;
         rsp_offset_ff <= step_result.offset;
         rsp_had_ff    <= step_result.had;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_parsed_value = rsp_value_ff;
   assign rsp_stop_offset  = rsp_offset_ff;
   assign rsp_had_digits   = rsp_had_ff;

endmodule

@@ sv/stu_checker.sv @@
// stu_checker: port-level checks for string_to_unsigned_parse, bound to it.
// Depends on stu_pkg and the top level.

module stu_checker import stu_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic [ValueBits-1:0]     rsp_parsed_value,
   input logic [OffsetOutBits-1:0] rsp_stop_offset,
   input logic                     rsp_had_digits
);

   // a waiting result word holds
   property p_rsp_hold;
      @(posedge clock) disable iff (reset)
         rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_parsed_value) &&
            $stable(rsp_stop_offset) && $stable(rsp_had_digits);
   endproperty
   a_rsp_hold: assert property (p_rsp_hold) else $error("rsp word changed while stalled");

   // reset empties the result register
   property p_reset_clears;
      @(posedge clock) reset |=> !rsp_valid;
   endproperty
   a_reset_clears: assert property (p_reset_clears) else $error("rsp_valid after reset");

   // no digits means value and offset are zero
   property p_no_digits;
      @(posedge clock) disable iff (reset)
         rsp_valid && !rsp_had_digits |-> rsp_parsed_value == '0 && rsp_stop_offset == '0;
   endproperty
   a_no_digits: assert property (p_no_digits) else $error("nonzero result without digits");

   // a fresh result must trace back to a byte accepted on req_
   property p_latency;
      @(posedge clock) disable iff (reset)
         $rose(rsp_valid) |-> $past(req_valid && req_ready, 2);
   endproperty
   a_latency: assert property (p_latency) else $error("result without matching byte");

endmodule

bind string_to_unsigned_parse stu_checker u_stu_checker (.*);
